// File: sv/bcg_pkg.sv
// ----------------------------------------------------------------------------
// bcg_pkg
// Shared types and constants for the button click gesture detector.
// ----------------------------------------------------------------------------
`default_nettype none

package bcg_pkg;

	localparam int TIME_BITS = 32;
	localparam int NOW_BITS  = 32;
	localparam int HIT_BITS  = 4;
	localparam int ADDR_BITS = 4;
	localparam int DATA_BITS = 32;

	localparam logic [HIT_BITS-1:0] HIT_MAX = 4'd15;

	localparam logic [1:0] REG_PULL_UP       = 2'd0;
	localparam logic [1:0] REG_CLICK_TIMEOUT = 2'd1;
	localparam logic [1:0] REG_PRESS_TIMEOUT = 2'd2;

	localparam logic [7:0]  CLICK_TIMEOUT_RST = 8'd200;
	localparam logic [15:0] PRESS_TIMEOUT_RST = 16'd1000;

	localparam logic CMD_REFRESH = 1'b0;
	localparam logic CMD_LEVEL   = 1'b1;

	typedef logic [TIME_BITS-1:0] time_t;

	typedef struct packed {
		logic        pull_up;
		logic [7:0]  click_timeout;
		logic [15:0] press_timeout;
	} cfg_t;

	typedef struct packed {
		logic                command;
		logic                level;
		logic [NOW_BITS-1:0] now_ms;
	} in_beat_t;

	typedef struct packed {
		logic press_event;
		logic release_event;
		logic long_release_event;
		logic click_event;
		logic double_click_event;
		logic long_press_event;
		logic active;
	} out_beat_t;

	typedef struct packed {
		logic                last_level_high;
		logic                held_flag;
		logic                gesture_active;
		logic [HIT_BITS-1:0] hit_count;
		time_t               gesture_start;
	} state_t;

endpackage

`default_nettype wire

// File: sv/bcg_in_if.sv
// ----------------------------------------------------------------------------
// bcg_in_if
// Input channel: command, pin level and millisecond time stamp.
// ----------------------------------------------------------------------------
`default_nettype none

interface bcg_in_if;
	logic                         valid;
	logic                         ready;
	logic                         command;
	logic                         level;
	logic [bcg_pkg::NOW_BITS-1:0] now_ms;

	modport source (output valid, command, level, now_ms, input ready);
	modport sink (input valid, command, level, now_ms, output ready);
endinterface

`default_nettype wire

// File: sv/bcg_out_if.sv
// ----------------------------------------------------------------------------
// bcg_out_if
// Result channel: gesture event flags and the active flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface bcg_out_if;
	logic valid;
	logic ready;
	logic press_event;
	logic release_event;
	logic long_release_event;
	logic click_event;
	logic double_click_event;
	logic long_press_event;
	logic active;

	modport source (output valid, press_event, release_event, long_release_event,
		click_event, double_click_event, long_press_event, active, input ready);
	modport sink (input valid, press_event, release_event, long_release_event,
		click_event, double_click_event, long_press_event, active, output ready);
endinterface

`default_nettype wire

// File: sv/bcg_regs.sv
// ----------------------------------------------------------------------------
// bcg_regs
// APB configuration registers: pull_up, click_timeout, press_timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module bcg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [bcg_pkg::ADDR_BITS-1:0] paddr,
	input  wire logic [bcg_pkg::DATA_BITS-1:0] pwdata,
	output logic      [bcg_pkg::DATA_BITS-1:0] prdata,
	output logic                               pready,
	output bcg_pkg::cfg_t                      cfg
);

	logic       wr_en;
	logic [1:0] reg_idx;
	logic       pull_up_q;
	logic [7:0] click_timeout_q;
	logic [15:0] press_timeout_q;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pull_up_q       <= 1'b0;
			click_timeout_q <= bcg_pkg::CLICK_TIMEOUT_RST;
			press_timeout_q <= bcg_pkg::PRESS_TIMEOUT_RST;
		end else if (wr_en && paddr[1:0] == 2'b00) begin
			case (reg_idx)
				bcg_pkg::REG_PULL_UP:       pull_up_q       <= pwdata[0];
				bcg_pkg::REG_CLICK_TIMEOUT: click_timeout_q <= pwdata[7:0];
				bcg_pkg::REG_PRESS_TIMEOUT: press_timeout_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_idx)
			bcg_pkg::REG_PULL_UP:       prdata = {31'd0, pull_up_q};
			bcg_pkg::REG_CLICK_TIMEOUT: prdata = {24'd0, click_timeout_q};
			bcg_pkg::REG_PRESS_TIMEOUT: prdata = {16'd0, press_timeout_q};
			default:                    prdata = '0;
		endcase
	end

	assign cfg.pull_up       = pull_up_q;
	assign cfg.click_timeout = click_timeout_q;
	assign cfg.press_timeout = press_timeout_q;

endmodule

`default_nettype wire

// File: sv/bcg_step.sv
// ----------------------------------------------------------------------------
// bcg_step
// One detector step: edge handling, then timeout checks, on the held state.
// ----------------------------------------------------------------------------
`default_nettype none

module bcg_step (
	input  bcg_pkg::cfg_t      cfg,
	input  bcg_pkg::state_t    cur,
	input  bcg_pkg::in_beat_t  beat,
	output bcg_pkg::state_t    nxt,
	output bcg_pkg::out_beat_t res
);

	localparam int PT_PAD = bcg_pkg::TIME_BITS - 16;
	localparam int CT_PAD = bcg_pkg::TIME_BITS - 8;

	bcg_pkg::time_t now;
	bcg_pkg::time_t dt_edge;
	bcg_pkg::time_t dt;
	bcg_pkg::time_t press_to;
	bcg_pkg::time_t click_to;
	logic           is_edge;
	logic           is_press;

	assign now      = bcg_pkg::time_t'(beat.now_ms);
	assign press_to = {{PT_PAD{1'b0}}, cfg.press_timeout};
	assign click_to = {{CT_PAD{1'b0}}, cfg.click_timeout};
	assign is_edge  = (beat.command == bcg_pkg::CMD_LEVEL) && (beat.level != cur.last_level_high);
	assign is_press = beat.level != cfg.pull_up;
	assign dt_edge  = now - cur.gesture_start;

	always_comb begin
		nxt = cur;
		res = '0;
		dt  = '0;

		if (is_edge) begin
			if (is_press) begin
				nxt.held_flag = 1'b1;
				if (!cur.gesture_active) begin
					nxt.gesture_active = 1'b1;
					nxt.gesture_start  = now;
				end
				res.press_event = 1'b1;
			end else if (dt_edge > press_to) begin
				res.long_release_event = 1'b1;
				nxt.held_flag          = 1'b0;
				nxt.gesture_active     = 1'b0;
				nxt.hit_count          = '0;
			end else begin
				res.release_event = 1'b1;
				if (cur.hit_count < bcg_pkg::HIT_MAX)
					nxt.hit_count = cur.hit_count + 1'b1;
				nxt.held_flag = 1'b0;
			end
			nxt.last_level_high = beat.level;
		end

		if (nxt.gesture_active) begin
			dt = now - nxt.gesture_start;
			if (dt >= press_to) begin
				res.long_press_event = nxt.held_flag && (nxt.hit_count == '0);
				nxt.held_flag      = 1'b0;
				nxt.gesture_active = 1'b0;
				nxt.hit_count      = '0;
			end else if (dt >= click_to && !nxt.held_flag) begin
				res.click_event        = nxt.hit_count == bcg_pkg::HIT_BITS'(1);
				res.double_click_event = nxt.hit_count == bcg_pkg::HIT_BITS'(2);
				nxt.held_flag      = 1'b0;
				nxt.gesture_active = 1'b0;
				nxt.hit_count      = '0;
			end
		end

		res.active = nxt.gesture_active;
	end

endmodule

`default_nettype wire

// File: sv/button_click_gesture_detector.sv
// ----------------------------------------------------------------------------
// button_click_gesture_detector
// Press, release, click, double-click and long-press detection on a pin.
// ----------------------------------------------------------------------------
// Usage:
//   din carries one beat per pin sample or time refresh (command, level,
//   now_ms). dout returns exactly one beat per input beat with the event
//   flags and the active flag after that step.
//   The APB port sets pull_up (0x0), click_timeout (0x4) and press_timeout
//   (0x8); write them only while no beat is in flight.
// Path: the input register captures the accepted beat, then the combinational
//   step logic feeds the result register, which holds it until dout takes it.
// Throughput: one beat per cycle while dout is not held off; the step logic
//   on the gesture state is the only loop.
// Reset: arst_n clears the gesture state, both pipeline valids and loads the
//   register defaults (pull_up 0, click_timeout 200, press_timeout 1000).
// Stall: while dout is held off the result register keeps its beat; one more
//   beat is taken into the input register, then din.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module button_click_gesture_detector (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	bcg_in_if.sink                             din,
	bcg_out_if.source                          dout,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [bcg_pkg::ADDR_BITS-1:0] paddr,
	input  wire logic [bcg_pkg::DATA_BITS-1:0] pwdata,
	output logic      [bcg_pkg::DATA_BITS-1:0] prdata,
	output logic                               pready
);

	bcg_pkg::cfg_t      cfg;
	bcg_pkg::state_t    state_q;
	bcg_pkg::state_t    state_nxt;
	bcg_pkg::in_beat_t  beat_s1;
	bcg_pkg::out_beat_t res_nxt;
	bcg_pkg::out_beat_t res_s2;
	logic               valid_s1;
	logic               valid_s2;
	logic               adv;
	logic               fire;

	bcg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bcg_step u_step (
		.cfg  (cfg),
		.cur  (state_q),
		.beat (beat_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	assign adv       = !valid_s2 || dout.ready;
	assign fire      = valid_s1 && adv;
	assign din.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (din.ready)
				valid_s1 <= din.valid;
			if (adv)
				valid_s2 <= valid_s1;
			if (fire)
				state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (din.valid && din.ready) begin
			beat_s1.command <= din.command;
			beat_s1.level   <= din.level;
			beat_s1.now_ms  <= din.now_ms;
		end
		if (fire)
			res_s2 <= res_nxt;
	end

	assign dout.valid              = valid_s2;
	assign dout.press_event        = res_s2.press_event;
	assign dout.release_event      = res_s2.release_event;
	assign dout.long_release_event = res_s2.long_release_event;
	assign dout.click_event        = res_s2.click_event;
	assign dout.double_click_event = res_s2.double_click_event;
	assign dout.long_press_event   = res_s2.long_press_event;
	assign dout.active             = res_s2.active;

`ifndef SYNTHESIS
	a_active_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (dout.active == state_q.gesture_active))
		else $error("active flag differs from gesture state");

	a_held_in_gesture: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.held_flag |-> state_q.gesture_active)
		else $error("held flag set outside a gesture");

	a_one_edge_kind: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> $countones({res_s2.press_event, res_s2.release_event,
			res_s2.long_release_event}) <= 1)
		else $error("more than one edge event in one beat");

	a_one_judgement: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> $countones({res_s2.click_event, res_s2.double_click_event,
			res_s2.long_press_event}) <= 1)
		else $error("more than one timeout event in one beat");
`endif

endmodule

`default_nettype wire
